// File: sv/idm_pkg.sv
// ---------------------------------------------------------------------------
// idm_pkg: shared types and constants for the 16-bit divide/modulo unit
// Request and response payloads, the per-cell working word and the
// two's complement negate helper used on entry and at the sign fix-up.
// ---------------------------------------------------------------------------
package idm_pkg;

   localparam int IDM_DATA_WIDTH = 16;

   typedef logic [IDM_DATA_WIDTH-1:0] idm_word_type;

   typedef struct packed {
      logic         req_type;
      idm_word_type dividend;
      idm_word_type divisor;
   } idm_req_type;

   typedef struct packed {
      idm_word_type quotient;
      idm_word_type remainder;
   } idm_rsp_type;

   // Working word carried from cell to cell
   typedef struct packed {
      logic         neg_quo;
      logic         neg_rem;
      logic         den_zero;
      idm_word_type rem;
      idm_word_type work;
      idm_word_type den;
   } idm_work_type;

   function automatic idm_word_type idm_negate(input idm_word_type x);
      idm_word_type res;
      res = ~x + idm_word_type'(1);
      return res;
   endfunction

endpackage

// File: sv/idm_cell.sv
// ---------------------------------------------------------------------------
// idm_cell: one restoring division step
// Shift the next dividend bit into the partial remainder, trial-subtract
// the divisor, keep or restore, and shift the quotient bit into the word.
// ---------------------------------------------------------------------------
module idm_cell
   import idm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         prev_valid,
   input  idm_work_type prev_data,
   output logic         next_valid,
   output idm_work_type next_data
);

   logic [IDM_DATA_WIDTH+1:0] diff;
   logic                      quo_bit;
   logic                      valid_ff;
   idm_work_type              data_ff;
   idm_work_type              data_in;

   always_comb begin
      diff = {1'b0, prev_data.rem, prev_data.work[IDM_DATA_WIDTH-1]}
             - {2'b00, prev_data.den};
      quo_bit = ~diff[IDM_DATA_WIDTH+1];
      data_in = prev_data;
      if (quo_bit) begin
         data_in.rem = diff[IDM_DATA_WIDTH-1:0];
      end else begin
         data_in.rem = {prev_data.rem[IDM_DATA_WIDTH-2:0],
                        prev_data.work[IDM_DATA_WIDTH-1]};
      end
      data_in.work = {prev_data.work[IDM_DATA_WIDTH-2:0], quo_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign next_valid = valid_ff;
   assign next_data  = data_ff;

endmodule

// File: sv/idm_fixup.sv
// ---------------------------------------------------------------------------
// idm_fixup: sign correction and response register
// Apply the result signs, force a zero quotient on divide by zero and
// hold the response until the consumer takes it.
// ---------------------------------------------------------------------------
module idm_fixup
   import idm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         last_valid,
   input  idm_work_type last_data,
   output logic         rsp_valid,
   output idm_rsp_type  rsp_payload
);

   logic        rsp_valid_ff;
   idm_rsp_type rsp_payload_ff;
   idm_rsp_type rsp_payload_in;

   always_comb begin
      if (last_data.den_zero) begin
         rsp_payload_in.quotient = '0;
      end else if (last_data.neg_quo) begin
         rsp_payload_in.quotient = idm_negate(last_data.work);
      end else begin
         rsp_payload_in.quotient = last_data.work;
      end
      if (last_data.neg_rem) begin
         rsp_payload_in.remainder = idm_negate(last_data.rem);
      end else begin
         rsp_payload_in.remainder = last_data.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: sv/int16_divide_modulo_unit.sv
// ---------------------------------------------------------------------------
// int16_divide_modulo_unit: 16-bit signed/unsigned divide and modulo
// Restoring shift-subtract divider built as a chain of one-bit cells.
// ---------------------------------------------------------------------------
// Each request carries a 16-bit dividend, a 16-bit divisor and a selector
// (req_type: 0 unsigned, 1 signed two's complement) and yields one response
// with the quotient, truncated toward zero, and the remainder, which carries
// the dividend's sign. Signed requests divide magnitudes and fix the signs
// at the end, so the most negative value over minus one wraps back to the
// most negative value with remainder zero. A zero divisor gives quotient
// zero and the dividend bits as remainder; no error is flagged. A request
// passes through an entry register (operand magnitudes), sixteen division
// cells that each settle one quotient bit, and the sign fix-up register
// that drives the response: eighteen registers in all. Every stage moves
// on together, so a new request is taken every cycle while the response
// register is free or being taken; when rsp_stall holds a response the
// whole chain holds with it and req_stall rises. The block keeps no state
// between requests.
// ---------------------------------------------------------------------------
module int16_divide_modulo_unit
   import idm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  idm_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output idm_rsp_type rsp_payload
);

   logic         advance;
   logic         in_valid_ff;
   idm_work_type in_data_ff;
   idm_work_type in_data_in;
   logic         dividend_neg;
   logic         divisor_neg;

   // Chain taps: tap 0 is the entry register, tap N the last cell
   logic         tap_valid [IDM_DATA_WIDTH+1];
   idm_work_type tap_data  [IDM_DATA_WIDTH+1];

   // Move the whole chain whenever the response register can be refilled
   assign advance   = ~rsp_valid | ~rsp_stall;
   assign req_stall = ~advance;

   // Take magnitudes and record which results need negating
   always_comb begin
      dividend_neg = req_payload.req_type & req_payload.dividend[IDM_DATA_WIDTH-1];
      divisor_neg  = req_payload.req_type & req_payload.divisor[IDM_DATA_WIDTH-1];
      in_data_in.neg_quo  = dividend_neg ^ divisor_neg;
      in_data_in.neg_rem  = dividend_neg;
      in_data_in.den_zero = (req_payload.divisor == '0);
      in_data_in.rem      = '0;
      in_data_in.work     = dividend_neg ? idm_negate(req_payload.dividend)
                                         : req_payload.dividend;
      in_data_in.den      = divisor_neg ? idm_negate(req_payload.divisor)
                                        : req_payload.divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_data_ff <= in_data_in;
      end
   end

   assign tap_valid[0] = in_valid_ff;
   assign tap_data[0]  = in_data_ff;

   // One cell per quotient bit, most significant first
   for (genvar i = 0; i < IDM_DATA_WIDTH; i++) begin : g_cell
      idm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .prev_valid (tap_valid[i]),
         .prev_data  (tap_data[i]),
         .next_valid (tap_valid[i+1]),
         .next_data  (tap_data[i+1])
      );
   end

   // Apply signs and hold the response
   idm_fixup u_fixup (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .last_valid  (tap_valid[IDM_DATA_WIDTH]),
      .last_data   (tap_data[IDM_DATA_WIDTH]),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: tb/int16_divide_modulo_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// int16_divide_modulo_unit_tb: self-checking bench for the divide/modulo unit
// Drives corner-case and random requests through the valid/stall channels
// under several idling patterns. A scoreboard predicts quotient and
// remainder for every accepted request and compares each response in order.
// ---------------------------------------------------------------------------
module int16_divide_modulo_unit_tb
   import idm_pkg::*;
();

   // Division mode selector carried in req_type
   localparam logic DIV_UNSIGNED = 1'b0;
   localparam logic DIV_SIGNED   = 1'b1;

   // Allow generous margin after the unit's latency when draining
   localparam int DRAIN_CYCLES  = 40;
   // Longest legitimate quiet stretch is the latency plus a run of idle or
   // stall cycles; anything this long means the unit has hung
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_PER_PHASE = 306;

   localparam idm_req_type CORNER_CASES [21] = '{
      '{DIV_UNSIGNED, 16'h0000, 16'h0001},
      '{DIV_UNSIGNED, 16'hFFFF, 16'h0001},
      '{DIV_UNSIGNED, 16'hFFFF, 16'hFFFF},
      '{DIV_UNSIGNED, 16'h1234, 16'h0000},   // divide by zero
      '{DIV_UNSIGNED, 16'hFFFF, 16'h0000},   // divide by zero, all ones
      '{DIV_UNSIGNED, 16'h0007, 16'hFFFF},   // quotient zero
      '{DIV_UNSIGNED, 16'h8000, 16'h7FFF},
      '{DIV_UNSIGNED, 16'hFFFF, 16'h8000},
      '{DIV_UNSIGNED, 16'h7FFF, 16'h0003},
      '{DIV_SIGNED,   16'h8000, 16'hFFFF},   // most negative over minus one
      '{DIV_SIGNED,   16'h8000, 16'h0001},
      '{DIV_SIGNED,   16'h8000, 16'h0000},   // divide by zero, negative dividend
      '{DIV_SIGNED,   16'h0000, 16'h0000},
      '{DIV_SIGNED,   16'h7FFF, 16'h8000},
      '{DIV_SIGNED,   16'h8000, 16'h8000},
      '{DIV_SIGNED,   16'hFFF9, 16'h0002},   // -7 / 2
      '{DIV_SIGNED,   16'h0007, 16'hFFFE},   // 7 / -2
      '{DIV_SIGNED,   16'hFFF9, 16'hFFFE},   // -7 / -2
      '{DIV_SIGNED,   16'h0007, 16'h0002},
      '{DIV_SIGNED,   16'h7FFF, 16'hFFFF},
      '{DIV_SIGNED,   16'hFFFF, 16'h7FFF}
   };

   // Expected quotient/remainder store with its own division predictor
   class divide_scoreboard;
      idm_rsp_type expected_q [$];
      int unsigned fails = 0;

      // Work out the response for an accepted request and queue it
      function void note_request(idm_req_type req);
         idm_word_type num;
         idm_word_type den;
         idm_word_type quo;
         idm_word_type rem;
         logic         num_neg;
         logic         den_neg;
         idm_rsp_type  want;
         num     = req.dividend;
         den     = req.divisor;
         num_neg = 1'b0;
         den_neg = 1'b0;
         if (req.req_type == DIV_SIGNED) begin
            if (num[IDM_DATA_WIDTH-1]) begin
               num_neg = 1'b1;
               num     = -num;
            end
            if (den[IDM_DATA_WIDTH-1]) begin
               den_neg = 1'b1;
               den     = -den;
            end
         end
         if (den == '0) begin
            quo = '0;
            rem = num;
         end else begin
            quo = num / den;
            rem = num % den;
         end
         if (num_neg != den_neg) quo = -quo;
         if (num_neg) rem = -rem;
         want.quotient  = quo;
         want.remainder = rem;
         expected_q.push_back(want);
      endfunction

      // Compare an accepted response against the oldest expectation
      function void check_response(idm_rsp_type got);
         idm_rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response q=%h r=%h", $time, got.quotient, got.remainder);
            fails++;
            return;
         end
         want = expected_q.pop_front();
         if (got.quotient !== want.quotient) begin
            $display("%0t: quotient mismatch: expected %h, actual %h",
                     $time, want.quotient, got.quotient);
            fails++;
         end
         if (got.remainder !== want.remainder) begin
            $display("%0t: remainder mismatch: expected %h, actual %h",
                     $time, want.remainder, got.remainder);
            fails++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   idm_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   idm_rsp_type rsp_payload;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned quiet_cycles   = 0;

   divide_scoreboard sb = new();

   int16_divide_modulo_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Present one request, holding it until the unit takes it. Idle cycles are
   // inserted beforehand at the current sender idle rate.
   task automatic send_request(input idm_req_type req);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= req;
      do @(posedge clock); while (req_stall);
      sb.note_request(req);
   endtask

   // Bias operands towards zero, the extremes and small magnitudes of either
   // sign, so the zero divisor and sign fix-up paths are hit often
   function automatic idm_word_type pick_operand();
      int unsigned  sel;
      idm_word_type w;
      sel = $urandom_range(9);
      if (sel == 0) begin
         w = '0;
      end else if (sel == 1) begin
         case ($urandom_range(3))
            0: w = 16'h0001;
            1: w = 16'hFFFF;
            2: w = 16'h8000;
            default: w = 16'h7FFF;
         endcase
      end else if (sel <= 3) begin
         w = idm_word_type'($urandom_range(9));
         if ($urandom_range(1) == 1) w = -w;
      end else begin
         w = idm_word_type'($urandom);
      end
      return w;
   endfunction

   // Response side: check each accepted response, roll the stall for the
   // next cycle and keep the hang watchdog
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_payload);
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request or response accepted for %0d cycles",
                     $time, QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      idm_req_type req;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Corner cases back to back, no idling
      foreach (CORNER_CASES[i]) send_request(CORNER_CASES[i]);

      // Random requests under each idling pattern: none, sender idle,
      // receiver stalling, then both lightly
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         repeat (RANDOM_PER_PHASE) begin
            req.req_type = ($urandom_range(1) == 1) ? DIV_SIGNED : DIV_UNSIGNED;
            req.dividend = pick_operand();
            req.divisor  = pick_operand();
            send_request(req);
         end
      end
      req_valid <= 1'b0;

      // Drain outstanding responses, then let any stray ones show up
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.fails == 0 && sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
